// File: hw/rtl/fbfla_pkg.sv
`timescale 1ns / 1ps

package fbfla_pkg;

	// fixed field widths
	localparam int ADDR_W   = 48;
	localparam int SIZE_W   = 21;
	localparam int COUNT_W  = 11;
	localparam int INDEX_W  = 10;
	localparam int REG_W    = 2;

	// register reset values
	localparam logic [SIZE_W-1:0]  SIZE_RST  = 21'd4096;
	localparam logic [COUNT_W-1:0] COUNT_RST = 11'd1024;

	// request codes
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	typedef enum logic [REG_W-1:0] {
		REG_BASE  = 2'd0,
		REG_SIZE  = 2'd1,
		REG_COUNT = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC_RD,
		S_ALLOC_MUL,
		S_ALLOC_FIN,
		S_FREE_PREP,
		S_FREE_DIV,
		S_FREE_FIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic cfg_wr;
		logic rd;
		logic mul;
		logic prep;
		logic div_step;
		logic res_alloc;
		logic res_empty;
		logic res_range;
		logic res_full;
		logic res_push;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic out_of_range;
		logic full;
		logic div_last;
		logic out_busy;
	} stat_t;

endpackage

// File: hw/rtl/fbfla_ctrl.sv
`timescale 1ns / 1ps

module fbfla_ctrl import fbfla_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  action,
	input  logic  cfg_valid,
	output logic  cfg_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				// a register write goes ahead of a waiting request
				in_ready   = !cfg_valid;
				cfg_ready  = 1'b1;
				cmd.cfg_wr = cfg_valid;
				if (in_valid && !cfg_valid) begin
					cmd.capture = 1'b1;
					state_d = (action == ACT_FREE) ? S_FREE_PREP : S_ALLOC_RD;
				end
			end
			S_ALLOC_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_ALLOC_MUL;
			end
			S_ALLOC_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ALLOC_FIN;
			end
			S_ALLOC_FIN: begin
				if (!st.out_busy) begin
					if (st.empty) begin
						cmd.res_empty = 1'b1;
					end else begin
						cmd.res_alloc = 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			S_FREE_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_FREE_DIV;
			end
			S_FREE_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = S_FREE_FIN;
				end
			end
			S_FREE_FIN: begin
				if (!st.out_busy) begin
					priority if (st.out_of_range) begin
						cmd.res_range = 1'b1;
					end else if (st.full) begin
						cmd.res_full = 1'b1;
					end else begin
						cmd.res_push = 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// at most one result per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.res_alloc, cmd.res_empty, cmd.res_range, cmd.res_full, cmd.res_push}))
		else $error("more than one result command");

	// a result never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_alloc || cmd.res_empty || cmd.res_range || cmd.res_full || cmd.res_push)
		|-> !st.out_busy)
		else $error("result issued while output held");

	// an accepted request always leaves idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && in_ready) |=> (state_q != S_IDLE))
		else $error("accepted request not started");

endmodule

// File: hw/rtl/fbfla_dp.sv
`timescale 1ns / 1ps

module fbfla_dp import fbfla_pkg::*; #(
	parameter int MAX_BLOCKS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              st,
	input  logic [REG_W-1:0]   cfg_index,
	input  logic [ADDR_W-1:0]  cfg_data,
	input  logic [ADDR_W-1:0]  freed_address,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ADDR_W-1:0]  block_address,
	output logic [INDEX_W-1:0] block_index,
	output logic [1:0]         status
);

	localparam int IW   = $clog2(MAX_BLOCKS);
	localparam int CW   = $clog2(MAX_BLOCKS + 1);
	localparam int CNTW = (IW > 1) ? $clog2(IW) : 1;
	localparam int DW   = SIZE_W + IW;
	localparam int LW   = SIZE_W + CW;
	localparam int WW   = (LW > ADDR_W) ? LW : ADDR_W;
	localparam logic [CW-1:0] CNT_RST_EFF =
		(int'(COUNT_RST) > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(COUNT_RST);

	// configuration registers
	logic [ADDR_W-1:0]  base_q;
	logic [SIZE_W-1:0]  size_q;
	logic [COUNT_W-1:0] count_q;

	// queue control
	logic [IW-1:0] head_q;
	logic [CW-1:0] fcnt_q;
	logic [CW-1:0] wcnt_q;

	// queue storage and read path
	logic [IW-1:0] queue_mem [MAX_BLOCKS];
	logic [IW-1:0] rd_data_q;
	logic          written_q;

	// alloc and free working registers
	logic [IW-1:0] idx_q;
	logic [DW-1:0] prod_q;
	logic [WW-1:0] off_q;
	logic [WW-1:0] limit_q;
	logic [WW-1:0] rem_q;
	logic [WW-1:0] dvs_q;
	logic [IW-1:0] quot_q;
	logic [CNTW-1:0] cnt_q;

	// output register
	logic               out_valid_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [INDEX_W-1:0] index_q;
	status_t            status_q;

	logic [SIZE_W-1:0] eff_size;
	logic [CW-1:0]     eff_n;
	logic [CW:0]       pos_w;
	logic [CW:0]       n_w;
	logic [CW:0]       head_ofs;
	logic [CW:0]       tail_sum;
	logic [IW-1:0]     tail;
	logic [IW-1:0]     head_nxt;
	logic [IW-1:0]     alloc_idx;
	logic [DW-1:0]     prod_w;
	logic [LW-1:0]     limit_w;
	logic              ge;
	logic [WW-1:0]     rem_sub;
	logic [IW:0]       quot_sh;

	function automatic logic [CW-1:0] clamp_count(input logic [COUNT_W-1:0] c);
		return (int'(c) > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(c);
	endfunction

	assign eff_size = (size_q == '0) ? SIZE_W'(1) : size_q;
	assign eff_n    = clamp_count(count_q);

	// positions written since the last reload run from eff_n upward around the ring
	assign pos_w    = (CW+1)'(head_q);
	assign n_w      = (CW+1)'(eff_n);
	assign head_ofs = (pos_w >= n_w) ? (pos_w - n_w) : (pos_w + (CW+1)'(MAX_BLOCKS) - n_w);

	// tail of the ring
	assign tail_sum = (CW+1)'(head_q) + (CW+1)'(fcnt_q);
	assign tail     = (tail_sum >= (CW+1)'(MAX_BLOCKS)) ?
		IW'(tail_sum - (CW+1)'(MAX_BLOCKS)) : IW'(tail_sum);
	assign head_nxt = ((CW+1)'(head_q) + 1'b1 == (CW+1)'(MAX_BLOCKS)) ? '0 : head_q + 1'b1;

	// untouched entries still hold their reload value, the position itself
	assign alloc_idx = written_q ? rd_data_q : head_q;
	assign prod_w    = DW'(alloc_idx) * DW'(eff_size);
	assign limit_w   = LW'(eff_n) * LW'(eff_size);

	// restoring divider step, one quotient bit per cycle
	assign ge      = (rem_q >= dvs_q);
	assign rem_sub = rem_q - dvs_q;
	assign quot_sh = {quot_q, ge};

	// status to controller
	assign st.empty        = (fcnt_q == '0);
	assign st.out_of_range = (off_q >= limit_q);
	assign st.full         = (fcnt_q >= eff_n);
	assign st.div_last     = (cnt_q == '0);
	assign st.out_busy     = out_valid_q && !out_ready;

	// configuration and queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			size_q  <= SIZE_RST;
			count_q <= COUNT_RST;
			head_q  <= '0;
			fcnt_q  <= CNT_RST_EFF;
			wcnt_q  <= '0;
		end else begin
			if (cmd.cfg_wr) begin
				unique case (cfg_index)
					REG_BASE: base_q <= cfg_data;
					REG_SIZE: size_q <= cfg_data[SIZE_W-1:0];
					REG_COUNT: begin
						count_q <= cfg_data[COUNT_W-1:0];
						head_q  <= '0;
						fcnt_q  <= clamp_count(cfg_data[COUNT_W-1:0]);
						wcnt_q  <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.res_alloc) begin
				head_q <= head_nxt;
				fcnt_q <= fcnt_q - 1'b1;
			end
			if (cmd.res_push) begin
				fcnt_q <= fcnt_q + 1'b1;
				if (wcnt_q != CW'(MAX_BLOCKS)) begin
					wcnt_q <= wcnt_q + 1'b1;
				end
			end
		end
	end

	// queue memory
	always_ff @(posedge clk) begin
		if (cmd.res_push) begin
			queue_mem[tail] <= quot_q;
		end
		if (cmd.rd) begin
			rd_data_q <= queue_mem[head_q];
			written_q <= (head_ofs < (CW+1)'(wcnt_q));
		end
	end

	// alloc address and free divider
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			off_q <= WW'(freed_address - base_q);
		end
		if (cmd.mul) begin
			idx_q  <= alloc_idx;
			prod_q <= prod_w;
		end
		if (cmd.prep) begin
			limit_q <= WW'(limit_w);
			rem_q   <= off_q;
			dvs_q   <= WW'(eff_size) << (IW - 1);
			quot_q  <= '0;
			cnt_q   <= CNTW'(IW - 1);
		end
		if (cmd.div_step) begin
			if (ge) begin
				rem_q <= rem_sub;
			end
			dvs_q  <= dvs_q >> 1;
			quot_q <= quot_sh[IW-1:0];
			cnt_q  <= cnt_q - 1'b1;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_alloc || cmd.res_empty || cmd.res_range ||
				cmd.res_full || cmd.res_push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.res_alloc) begin
			addr_q   <= base_q + ADDR_W'(prod_q);
			index_q  <= INDEX_W'(idx_q);
			status_q <= STAT_OK;
		end
		if (cmd.res_empty) begin
			addr_q   <= '0;
			index_q  <= '0;
			status_q <= STAT_EMPTY;
		end
		if (cmd.res_range) begin
			addr_q   <= '0;
			index_q  <= '0;
			status_q <= STAT_RANGE;
		end
		if (cmd.res_full) begin
			addr_q   <= '0;
			index_q  <= INDEX_W'(quot_q);
			status_q <= STAT_FULL;
		end
		if (cmd.res_push) begin
			addr_q   <= '0;
			index_q  <= INDEX_W'(quot_q);
			status_q <= STAT_OK;
		end
	end

	assign out_valid     = out_valid_q;
	assign block_address = addr_q;
	assign block_index   = index_q;
	assign status        = status_q;

	// queue occupancy never exceeds the pool size
	assert property (@(posedge clk) disable iff (!arst_n) fcnt_q <= eff_n)
		else $error("free count above block count");

	// a push only happens with room in the queue
	assert property (@(posedge clk) disable iff (!arst_n) cmd.res_push |-> (fcnt_q < eff_n))
		else $error("push into full queue");

	// a pop only happens on a non-empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_alloc |-> (fcnt_q != '0) && ((CW+1)'(head_q) < (CW+1)'(MAX_BLOCKS)))
		else $error("pop from empty queue");

endmodule

// File: hw/rtl/fifo_block_free_list_allocator.sv
`timescale 1ns / 1ps

// Block allocator over a pool of equal-sized blocks, with free indices kept in a
// FIFO ring. A request with action 0 pops the oldest free index and returns
// base_address + block_size * index; action 1 turns freed_address into an index
// by (freed_address - base_address) / block_size and pushes it back, answering
// out of range or queue full instead when it cannot, and an allocate with no
// free index answers empty. One result per request. Requests are handled one
// at a time: an allocate reads the queue memory, multiplies and adds into the
// output register; a free runs the restoring divider, which produces one
// quotient bit per cycle. A finished result waits in an output register while
// the next request is taken; a result not yet taken holds the next one in its
// last cycle for as long as the output stalls. Writing block_count reloads the
// queue with no clearing pass: entries not yet rewritten read back as their own
// position. Configuration writes are taken only while no request is in flight,
// and go ahead of a request waiting at the same time.
module fifo_block_free_list_allocator import fbfla_pkg::*; #(
	parameter int MAX_BLOCKS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [ADDR_W-1:0]  freed_address,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ADDR_W-1:0]  block_address,
	output logic [INDEX_W-1:0] block_index,
	output logic [1:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [REG_W-1:0]   cfg_index,
	input  logic [ADDR_W-1:0]  cfg_data
);

	cmd_t  cmd;
	stat_t st;

	// sequencing
	fbfla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// registers, queue, multiplier and divider
	fbfla_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.freed_address (freed_address),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.block_address (block_address),
		.block_index   (block_index),
		.status        (status)
	);

endmodule
